FILE: rtl/bfpa_pkg.sv
// shared types and constants of the best-fit page allocator
package bfpa_pkg;

	localparam int ADDR_W   = 32;
	localparam int BYTES_W  = 32;
	localparam int PCOUNT_W = 11;
	localparam int DVD_W    = BYTES_W + 1;

	// request kinds
	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOSPACE = 2'd1,
		ST_BADFREE = 2'd2
	} bfpa_status_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_CHECK,
		S_SCAN,
		S_SCAN_END,
		S_DECIDE,
		S_MARK,
		S_LOOK,
		S_FCHK,
		S_RELEASE,
		S_DONE
	} bfpa_state_t;

endpackage

FILE: rtl/bfpa_if.sv
// handshake channels of the allocator: configuration, request and response
interface bfpa_cfg_if import bfpa_pkg::*;;
	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface bfpa_req_if import bfpa_pkg::*;;
	logic               valid;
	logic               ready;
	logic               action;
	logic [BYTES_W-1:0] request_bytes;
	logic [ADDR_W-1:0]  free_address;

	modport source (output valid, output action, output request_bytes, output free_address,
		input ready);
	modport sink (input valid, input action, input request_bytes, input free_address,
		output ready);
endinterface

interface bfpa_rsp_if import bfpa_pkg::*;;
	logic                valid;
	logic                ready;
	bfpa_status_t        status;
	logic [ADDR_W-1:0]   address;
	logic [PCOUNT_W-1:0] page_count;

	modport source (output valid, output status, output address, output page_count,
		input ready);
	modport sink (input valid, input status, input address, input page_count,
		output ready);
endinterface

FILE: rtl/best_fit_page_allocator_unit.sv
// Best-fit page allocator over NUM_PAGES pages of PAGE_BYTES bytes. PAGE_BYTES must be a
// power of two: byte sizes and offsets are split into pages by a shift and a mask. After
// reset the block runs a clearing pass over every page of its page memory and takes
// no request meanwhile. It then handles one request at a time. An allocate reads the page
// memory once from end to end, one page a cycle, then writes one granted page a cycle;
// when no run fits, nothing is written. A free reads the start page and writes one
// released page a cycle. A zero or oversized size, or a free address off the page grid or
// outside the heap, is answered straight after the check; a free of a page that starts no
// allocation is answered after its start page is read. The next request is taken while a
// finished response word still waits on the output; a stall only adds cycles once the
// following response is ready behind it.
module best_fit_page_allocator_unit import bfpa_pkg::*; #(
	parameter int NUM_PAGES  = 1024,
	parameter int PAGE_BYTES = 4096
) (
	input logic        clk,
	input logic        arst_n,
	bfpa_cfg_if.sink   cfg,
	bfpa_req_if.sink   req,
	bfpa_rsp_if.source rsp
);

	localparam int IDX_W     = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
	localparam int CNT_W     = $clog2(NUM_PAGES + 1);
	localparam int PB_SH     = $clog2(PAGE_BYTES);
	localparam int POS_W     = CNT_W + 1;
	localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(NUM_PAGES - 1);
	localparam logic [CNT_W-1:0]  NP_CNT    = CNT_W'(NUM_PAGES);
	localparam logic [POS_W-1:0]  LAST_POS  = POS_W'(NUM_PAGES - 1);
	localparam logic [DVD_W-1:0]  NP_DVD    = DVD_W'(NUM_PAGES);
	localparam logic [DVD_W-1:0]  ROUND_UP  = DVD_W'(PAGE_BYTES - 1);

	// page memory: used bit on top, run length at an allocation's first page below
	logic [CNT_W:0] mem [NUM_PAGES];
	logic [CNT_W:0] rdata_q;

	bfpa_state_t state_q, state_d;

	// control registers
	logic              rsp_valid_q;
	logic [ADDR_W-1:0] heap_base_q;
	logic [IDX_W-1:0]  clr_q;
	logic              pv_s1;

	// request and page split registers
	logic              action_q;
	logic [ADDR_W-1:0] faddr_q;
	logic [DVD_W-1:0]  quo_q;
	logic [PB_SH-1:0]  rem_q;

	// scan and write sweep registers
	logic [CNT_W-1:0] need_q;
	logic [CNT_W-1:0] sc_q;
	logic [CNT_W-1:0] idx_s1;
	logic [CNT_W-1:0] run_len_q;
	logic [IDX_W-1:0] run_start_q;
	logic [CNT_W-1:0] best_len_q;
	logic [IDX_W-1:0] best_start_q;
	logic             found_q;
	logic [IDX_W-1:0] idx_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] mk_q;

	// finished result and output word
	bfpa_status_t        res_status_q;
	logic [ADDR_W-1:0]   res_addr_q;
	logic [CNT_W-1:0]    res_cnt_q;
	bfpa_status_t        rsp_status_q;
	logic [ADDR_W-1:0]   rsp_addr_q;
	logic [PCOUNT_W-1:0] rsp_cnt_q;

	// combinational helpers
	logic [DVD_W-1:0] req_dvd;
	logic             alloc_bad;
	logic             free_bad;
	logic             fchk_bad;
	logic             page_free_s1;
	logic             fits_s1;
	logic [POS_W-1:0] rel_pos;
	logic [POS_W-1:0] mark_pos;
	logic             rel_last;
	logic             mark_last;
	logic             out_free;
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	logic [CNT_W:0]   mem_wdata;
	logic             mem_re;
	logic [IDX_W-1:0] mem_raddr;

	// rounded byte size or heap offset of the offered request, and decision terms
	assign req_dvd      = (req.action == ACT_ALLOC) ? DVD_W'(req.request_bytes) + ROUND_UP
		: {1'b0, req.free_address - heap_base_q};
	assign alloc_bad    = (quo_q == '0) || (quo_q > NP_DVD);
	assign free_bad     = (rem_q != '0) || (quo_q >= NP_DVD);
	assign fchk_bad     = !rdata_q[CNT_W] || (rdata_q[CNT_W-1:0] == '0);
	assign page_free_s1 = (idx_s1 < NP_CNT) && !rdata_q[CNT_W];
	assign fits_s1      = (run_len_q >= need_q) && (!found_q || (run_len_q < best_len_q));
	assign rel_pos      = POS_W'(idx_q) + POS_W'(mk_q);
	assign mark_pos     = POS_W'(best_start_q) + POS_W'(mk_q);
	assign rel_last     = (mk_q == cnt_q - 1'b1) || (rel_pos == LAST_POS);
	assign mark_last    = (mk_q == need_q - 1'b1);
	assign out_free     = !rsp_valid_q || rsp.ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (clr_q == LAST_IDX) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (req.valid) state_d = S_CHECK;
			end
			S_CHECK: begin
				if (action_q == ACT_ALLOC) state_d = alloc_bad ? S_DONE : S_SCAN;
				else state_d = free_bad ? S_DONE : S_LOOK;
			end
			S_SCAN: begin
				if (sc_q == NP_CNT) state_d = S_SCAN_END;
			end
			S_SCAN_END: state_d = S_DECIDE;
			S_DECIDE:   state_d = found_q ? S_MARK : S_DONE;
			S_MARK: begin
				if (mark_last) state_d = S_DONE;
			end
			S_LOOK: state_d = S_FCHK;
			S_FCHK: state_d = fchk_bad ? S_DONE : S_RELEASE;
			S_RELEASE: begin
				if (rel_last) state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_CLEAR;
		endcase
	end

	// memory port control and handshake outputs
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = idx_q;
		req.ready = 1'b0;
		case (state_q)
			S_CLEAR: mem_we = 1'b1;
			S_IDLE:  req.ready = 1'b1;
			S_SCAN: begin
				mem_re    = (sc_q != NP_CNT);
				mem_raddr = sc_q[IDX_W-1:0];
			end
			S_LOOK: mem_re = 1'b1;
			S_MARK: begin
				mem_we    = 1'b1;
				mem_waddr = mark_pos[IDX_W-1:0];
				mem_wdata = {1'b1, (mk_q == '0) ? need_q : CNT_W'(0)};
			end
			S_RELEASE: begin
				mem_we    = 1'b1;
				mem_waddr = rel_pos[IDX_W-1:0];
			end
			default: ;
		endcase
	end

	assign cfg.ready      = 1'b1;
	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = rsp_status_q;
	assign rsp.address    = rsp_addr_q;
	assign rsp.page_count = rsp_cnt_q;

	// page memory, one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (mem_re) rdata_q <= mem[mem_raddr];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			rsp_valid_q <= 1'b0;
			heap_base_q <= '0;
			clr_q       <= '0;
			pv_s1       <= 1'b0;
		end else begin
			state_q <= state_d;
			pv_s1   <= (state_q == S_SCAN);
			if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
			if (cfg.valid) heap_base_q <= cfg.data;
			if (state_q == S_DONE && out_free) rsp_valid_q <= 1'b1;
			else if (rsp.ready) rsp_valid_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		// free run tracking on the word read the cycle before
		if (pv_s1) begin
			if (page_free_s1) begin
				if (run_len_q == '0) run_start_q <= idx_s1[IDX_W-1:0];
				run_len_q <= run_len_q + 1'b1;
			end else begin
				if (fits_s1) begin
					found_q      <= 1'b1;
					best_len_q   <= run_len_q;
					best_start_q <= run_start_q;
				end
				run_len_q <= '0;
			end
		end
		case (state_q)
			// split the request into pages and the offset within a page
			S_IDLE: begin
				action_q <= req.action;
				faddr_q  <= req.free_address;
				quo_q    <= req_dvd >> PB_SH;
				rem_q    <= req_dvd[PB_SH-1:0];
			end
			S_CHECK: begin
				need_q    <= quo_q[CNT_W-1:0];
				idx_q     <= quo_q[IDX_W-1:0];
				sc_q      <= '0;
				run_len_q <= '0;
				found_q   <= 1'b0;
				res_addr_q <= '0;
				res_cnt_q  <= '0;
				res_status_q <= (action_q == ACT_ALLOC) ? ST_NOSPACE : ST_BADFREE;
			end
			S_SCAN: begin
				idx_s1 <= sc_q;
				if (sc_q != NP_CNT) sc_q <= sc_q + 1'b1;
			end
			S_DECIDE: begin
				mk_q       <= '0;
				res_addr_q <= found_q ? heap_base_q + (ADDR_W'(best_start_q) << PB_SH) : '0;
				res_cnt_q  <= found_q ? need_q : '0;
				res_status_q <= found_q ? ST_OK : ST_NOSPACE;
			end
			S_MARK: mk_q <= mk_q + 1'b1;
			S_FCHK: begin
				mk_q  <= '0;
				cnt_q <= rdata_q[CNT_W-1:0];
				if (!fchk_bad) begin
					res_status_q <= ST_OK;
					res_addr_q   <= faddr_q;
					res_cnt_q    <= rdata_q[CNT_W-1:0];
				end
			end
			S_RELEASE: mk_q <= mk_q + 1'b1;
			// output word register
			S_DONE: begin
				if (out_free) begin
					rsp_status_q <= res_status_q;
					rsp_addr_q   <= res_addr_q;
					rsp_cnt_q    <= PCOUNT_W'(res_cnt_q);
				end
			end
			default: ;
		endcase
	end

endmodule

FILE: rtl/bfpa_checker.sv
// port checks of the allocator and their binding to the top level
module bfpa_checker import bfpa_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input logic [1:0]          rsp_status,
	input logic [ADDR_W-1:0]   rsp_address,
	input logic [PCOUNT_W-1:0] rsp_page_count
);

	// one request at a time: the input is not ready right after a request is taken
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while another is in work");

	// a failed request reports neither address nor pages
	a_fail_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status != ST_OK) |-> (rsp_address == '0) && (rsp_page_count == '0))
		else $error("failure word carries address or page count");

	// success always moves at least one page
	a_ok_pages: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == ST_OK) |-> (rsp_page_count != '0))
		else $error("success word with zero pages");

	// a stalled response word holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_address)
			&& $stable(rsp_page_count))
		else $error("response word changed while stalled");

endmodule

bind best_fit_page_allocator_unit bfpa_checker u_bfpa_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_status     (rsp.status),
	.rsp_address    (rsp.address),
	.rsp_page_count (rsp.page_count)
);
